// File: rtl/core/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants for the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int ID_W          = 8;
	localparam int CMD_W         = 2;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 5;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SCHED  = 2'd2,
		CMD_EXIT   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_NOCUR    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE  = 1'd0,
		REG_IDLE_ID = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS,
		S_SCHED
	} state_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic            shift;
		logic            we;
		logic [ID_W-1:0] wdata;
	} cell_ctrl_t;

endpackage

// File: rtl/core/rrq_cell.sv
// ----------------------------------------------------------------------------
// rrq_cell
// One slot of the ready queue: holds, takes its right neighbor or is written.
// ----------------------------------------------------------------------------
module rrq_cell (
	input  logic                     clk,
	input  rrq_pkg::cell_ctrl_t      ctrl,
	input  logic                     sel,
	input  logic [rrq_pkg::ID_W-1:0] right_data,
	output logic [rrq_pkg::ID_W-1:0] data
);
	import rrq_pkg::*;

	logic [ID_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.we && sel) begin
			slot_q <= ctrl.wdata;
		end else if (ctrl.shift) begin
			slot_q <= right_data;
		end
	end

	assign data = slot_q;

endmodule

// File: rtl/core/round_robin_ready_queue_core.sv
// ----------------------------------------------------------------------------
// round_robin_ready_queue_core
// Ready queue of task ids kept compacted in a chain of slot cells, with
// round-robin dispatch of the head.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------
//   command  | command, task_id                        | start & !busy
//   result   | status, switched, from_valid, from_task,| done, one cycle
//            | to_task, queue_count                    |
//   config   | cfg_we, cfg_index, cfg_data             | cfg_we
//
// add and the early-out cases finish in the accept cycle; schedule keeps busy
// high in S_SCHED, remove for a rotation pass in S_PASS and exit for that pass
// then S_SCHED; the pass walks the whole queue through the cell chain one slot
// a cycle. the result beat follows on done the cycle after the work ends.
// reset clears length, current task and config; slots are undefined until written.
// the receiver cannot stall, so busy is set only by the block's own work.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_core #(
	parameter int MAX_TASKS = rrq_pkg::MAX_TASKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rrq_pkg::CMD_W-1:0]      command,
	input  logic [rrq_pkg::ID_W-1:0]       task_id,
	input  logic                           cfg_we,
	input  logic [rrq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrq_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [rrq_pkg::STATUS_W-1:0]   status,
	output logic                           switched,
	output logic                           from_valid,
	output logic [rrq_pkg::ID_W-1:0]       from_task,
	output logic [rrq_pkg::ID_W-1:0]       to_task,
	output logic [rrq_pkg::COUNT_W-1:0]    queue_count
);
	import rrq_pkg::*;

	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int IW = $clog2(MAX_TASKS);

	state_t          state_q, state_d;
	logic [LW-1:0]   len_q, len_d, cnt_q, cnt_d, len_m1;
	logic [ID_W-1:0] cur_q, cur_d, key_q, key_d, idle_q;
	logic            cur_valid_q, cur_valid_d, running_q, running_d;
	logic            found_q, found_d, exit_q, exit_d, enable_q;

	cell_ctrl_t      cctrl;
	logic [IW-1:0]   widx;
	logic [ID_W-1:0] slot [MAX_TASKS];
	logic [ID_W-1:0] head, second, new_head;

	logic            accept, sched_noop, rotate, drop;
	cmd_t            cmd;

	logic            fire;
	status_t         res_status;
	logic            res_sw, res_fv;
	logic [ID_W-1:0] res_ft;
	logic [LW+COUNT_W-1:0] len_ext;

	// slot chain
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		logic [ID_W-1:0] right;
		if (i == MAX_TASKS - 1) begin : g_last
			assign right = slot[i];
		end else begin : g_mid
			assign right = slot[i+1];
		end
		rrq_cell u_cell (
			.clk        (clk),
			.ctrl       (cctrl),
			.sel        (widx == IW'(i)),
			.right_data (right),
			.data       (slot[i])
		);
	end

	assign head     = slot[0];
	assign second   = slot[1];
	assign cmd      = cmd_t'(command);
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign len_m1   = len_q - 1'b1;

	assign sched_noop = !enable_q || (len_q == '0) ||
		((len_q == LW'(1)) && (head == idle_q) && cur_valid_q && (cur_q == idle_q));
	assign rotate   = cur_valid_q && running_q && (head == cur_q);
	assign new_head = (rotate && (len_q > LW'(1))) ? second : head;
	assign drop     = !found_q && (head == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_REMOVE: state_d = (len_q != '0) ? S_PASS : S_IDLE;
						CMD_SCHED:  state_d = S_SCHED;
						CMD_EXIT:   state_d = cur_valid_q ? S_PASS : S_IDLE;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_PASS: begin
				if (cnt_q == '0) begin
					state_d = exit_q ? S_SCHED : S_IDLE;
				end
			end
			S_SCHED: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control and result
	always_comb begin
		cctrl       = '{shift: 1'b0, we: 1'b0, wdata: head};
		widx        = len_m1[IW-1:0];
		len_d       = len_q;
		cnt_d       = cnt_q;
		key_d       = key_q;
		found_d     = found_q;
		exit_d      = exit_q;
		cur_d       = cur_q;
		cur_valid_d = cur_valid_q;
		running_d   = running_q;
		fire        = 1'b0;
		res_status  = ST_OK;
		res_sw      = 1'b0;
		res_fv      = 1'b0;
		res_ft      = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_ADD: begin
							fire = 1'b1;
							if (len_q >= LW'(MAX_TASKS)) begin
								res_status = ST_FULL;
							end else begin
								cctrl.we    = 1'b1;
								cctrl.wdata = task_id;
								widx        = len_q[IW-1:0];
								len_d       = len_q + 1'b1;
								if (cur_valid_q && (cur_q == task_id)) begin
									running_d = 1'b0;
								end
							end
						end
						CMD_REMOVE: begin
							key_d   = task_id;
							cnt_d   = len_q;
							found_d = 1'b0;
							exit_d  = 1'b0;
							if (len_q == '0) begin
								fire       = 1'b1;
								res_status = ST_NOTFOUND;
							end
						end
						CMD_EXIT: begin
							if (!cur_valid_q) begin
								fire       = 1'b1;
								res_status = ST_NOCUR;
							end else begin
								running_d = 1'b0;
								key_d     = cur_q;
								cnt_d     = len_q;
								found_d   = 1'b0;
								exit_d    = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_PASS: begin
				if (cnt_q == '0) begin
					if (!exit_q) begin
						fire       = 1'b1;
						res_status = found_q ? ST_OK : ST_NOTFOUND;
					end
				end else begin
					// pop the head and append it at the tail, dropping the first match
					cctrl.shift = 1'b1;
					cnt_d       = cnt_q - 1'b1;
					if (drop) begin
						found_d = 1'b1;
						len_d   = len_m1;
					end else begin
						cctrl.we = 1'b1;
					end
				end
			end
			S_SCHED: begin
				fire = 1'b1;
				if (!sched_noop) begin
					if (rotate) begin
						cctrl.shift = 1'b1;
						cctrl.we    = 1'b1;
					end
					cur_d       = new_head;
					cur_valid_d = 1'b1;
					running_d   = 1'b1;
					if (!cur_valid_q) begin
						res_sw = 1'b1;
					end else if (cur_q != new_head) begin
						res_sw = 1'b1;
						res_fv = 1'b1;
						res_ft = cur_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign len_ext = {{COUNT_W{1'b0}}, len_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			running_q   <= 1'b0;
			found_q     <= 1'b0;
			exit_q      <= 1'b0;
			enable_q    <= 1'b0;
			idle_q      <= '0;
			done        <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			cnt_q       <= cnt_d;
			cur_q       <= cur_d;
			cur_valid_q <= cur_valid_d;
			running_q   <= running_d;
			found_q     <= found_d;
			exit_q      <= exit_d;
			done        <= fire;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ENABLE:  enable_q <= cfg_data[0];
					REG_IDLE_ID: idle_q   <= cfg_data[ID_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// result beat registers and the search key
	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (fire) begin
			status      <= res_status;
			switched    <= res_sw;
			from_valid  <= res_fv;
			from_task   <= res_ft;
			to_task     <= cur_valid_d ? cur_d : '0;
			queue_count <= len_ext[COUNT_W-1:0];
		end
	end

endmodule
